// ===== sv/disk_block_checksum_macros.svh =====
// Assertion shorthands used by the checker file.
`ifndef DISK_BLOCK_CHECKSUM_MACROS_SVH
`define DISK_BLOCK_CHECKSUM_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DBC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/dbc_pkg.sv =====
package dbc_pkg;

	localparam int BLOCK_WORDS = 128;

	localparam int WORD_W     = 32;
	localparam int IDX_W      = 7;
	localparam int MODE_W     = 2;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	localparam int CNT_W = $clog2(BLOCK_WORDS + 1);
	localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

	localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_STD  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BOOT = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_CHECK   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BOOT_MATCH = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MODE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INDEX = 1'd1;

	localparam logic [MODE_W-1:0] MODE_RESET  = MODE_STD;
	localparam logic [IDX_W-1:0]  INDEX_RESET = 7'd5;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [IDX_W-1:0]  index;
	} cfg_t;

	typedef struct packed {
		logic [WORD_W-1:0]   checksum;
		logic [STATUS_W-1:0] status;
	} result_t;

endpackage

// ===== sv/dbc_ifs.sv =====
interface dbc_in_if import dbc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] word;
	logic              last;

	modport source (output valid, output word, output last, input ready);
	modport sink (input valid, input word, input last, output ready);
endinterface

interface dbc_out_if import dbc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [WORD_W-1:0]   checksum;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output checksum, output status, input ready);
	modport sink (input valid, input checksum, input status, output ready);
endinterface

interface dbc_cfg_if import dbc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/disk_block_checksum.sv =====
// Disk block checksum engine. The block takes one 32-bit word per cycle
// unless the input waits as told below; the words of a block flow into an
// input register and are summed by a 32-bit adder (with end-around carry in
// boot mode). For the word marked last, the checksum and status pass through
// the output register onto the result channel, and the running state clears
// for the next block. A result waiting in the output register does not stop
// the next word from being taken; only when a further last word arrives
// behind it does the input wait. The user must change registers only while
// no block is in progress; the block itself does not enforce this.
module disk_block_checksum import dbc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	dbc_in_if.sink    data,
	dbc_out_if.source result,
	dbc_cfg_if.sink   cfg
);

	cfg_t    cfg_regs;
	logic    res_valid;
	logic    res_ready;
	result_t res;

	dbc_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cfg_regs (cfg_regs)
	);

	dbc_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.data      (data),
		.cfg_regs  (cfg_regs),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	dbc_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready),
		.result    (result)
	);

endmodule

// ===== sv/dbc_cfg_regs.sv =====
module dbc_cfg_regs import dbc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	dbc_cfg_if.sink   cfg,
	output cfg_t      cfg_regs
);

	logic [MODE_W-1:0] mode_q;
	logic [IDX_W-1:0]  index_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_RESET;
			index_q <= INDEX_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_MODE: begin
					mode_q <= cfg.data[MODE_W-1:0];
				end
				REG_INDEX: begin
					index_q <= cfg.data[IDX_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg_regs.mode  = mode_q;
	assign cfg_regs.index = index_q;

endmodule

// ===== sv/dbc_accum.sv =====
module dbc_accum import dbc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	dbc_in_if.sink  data,
	input  cfg_t    cfg_regs,
	output logic    res_valid,
	output result_t res,
	input  logic    res_ready
);

	logic              s1_valid;
	logic [WORD_W-1:0] s1_word;
	logic              s1_last;

	logic [WORD_W-1:0] sum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WORD_W-1:0] first_q;

	logic              advance;
	logic              in_first;
	logic              idx_hit;
	logic              idx_out;
	logic [WORD_W-1:0] w_eff;
	logic [WORD_W-1:0] first_nxt;
	logic [WORD_W:0]   sum_raw;
	logic [WORD_W-1:0] sum_nxt;

	assign advance    = s1_valid && (!s1_last || res_ready);
	assign data.ready = !s1_valid || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (data.valid && data.ready) begin
			s1_valid <= 1'b1;
		end else if (advance) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (data.valid && data.ready) begin
			s1_word <= data.word;
			s1_last <= data.last;
		end
	end

	assign in_first  = cnt_q < CNT_W'(BLOCK_WORDS);
	assign idx_hit   = CMP_W'(cnt_q) == CMP_W'(cfg_regs.index);
	assign idx_out   = CMP_W'(cfg_regs.index) >= CMP_W'(BLOCK_WORDS);
	assign w_eff     = (in_first && idx_hit) ? '0 : s1_word;
	assign first_nxt = (cnt_q == '0) ? w_eff : first_q;
	assign sum_raw   = {1'b0, sum_q} + {1'b0, w_eff};
	assign sum_nxt   = sum_raw[WORD_W-1:0]
		+ WORD_W'((cfg_regs.mode == MODE_BOOT) && sum_raw[WORD_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			cnt_q   <= '0;
			first_q <= '0;
		end else if (advance) begin
			if (s1_last) begin
				sum_q   <= '0;
				cnt_q   <= '0;
				first_q <= '0;
			end else begin
				sum_q   <= sum_nxt;
				cnt_q   <= cnt_q + CNT_W'(in_first);
				first_q <= first_nxt;
			end
		end
	end

	assign res_valid = s1_valid && s1_last;

	always_comb begin
		res.checksum = '0;
		res.status   = STATUS_OK;
		if (idx_out) begin
			res.status = STATUS_NO_CHECK;
		end else begin
			case (cfg_regs.mode)
				MODE_STD: begin
					res.checksum = '0 - sum_nxt;
				end
				MODE_BOOT: begin
					if (sum_nxt == first_nxt) begin
						res.status = STATUS_BOOT_MATCH;
					end else begin
						res.checksum = ~sum_nxt;
					end
				end
				default: begin
					res.status = STATUS_NO_CHECK;
				end
			endcase
		end
	end

endmodule

// ===== sv/dbc_out_stage.sv =====
module dbc_out_stage import dbc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      res_valid,
	input  result_t   res,
	output logic      res_ready,
	dbc_out_if.source result
);

	logic    out_valid_q;
	result_t out_q;

	assign res_ready = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.checksum = out_q.checksum;
	assign result.status   = out_q.status;

endmodule

// ===== sv/dbc_checker.sv =====
`include "disk_block_checksum_macros.svh"

module dbc_checker import dbc_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                in_last,
	input logic                out_valid,
	input logic                out_ready,
	input logic [WORD_W-1:0]   out_checksum,
	input logic [STATUS_W-1:0] out_status
);

	`DBC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_checksum) && $stable(out_status), "Result changed while stalled")

	`DBC_ASSERT_NOW(a_zero_on_status, clk, arst_n, out_valid && (out_status != STATUS_OK), out_checksum == '0, "Checksum not zero with nonzero status")

	`DBC_ASSERT_NOW(a_result_from_last, clk, arst_n, $rose(out_valid), $past(in_valid && in_ready && in_last, 2), "Result without a last word two cycles before")

	`DBC_ASSERT_NOW(a_stall_cause, clk, arst_n, !in_ready, out_valid && !out_ready, "Input held off without a stalled result")

endmodule

bind disk_block_checksum dbc_checker u_dbc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (data.valid),
	.in_ready     (data.ready),
	.in_last      (data.last),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.out_checksum (result.checksum),
	.out_status   (result.status)
);

// ===== verif/disk_block_checksum_tb.sv =====
`timescale 1ns / 100ps

module disk_block_checksum_tb;
	import dbc_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_WORDS = 1200;

	typedef struct {
		logic [WORD_W-1:0] word;
		logic              last;
	} word_req_t;

	typedef enum int {BLK_RANDOM, BLK_BOOT_MATCH, BLK_ONES, BLK_EXTREME} blk_kind_t;
	typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PERIODIC} stall_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dbc_in_if  data_if ();
	dbc_out_if result_if ();
	dbc_cfg_if cfg_if ();

	disk_block_checksum u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.data   (data_if),
		.result (result_if),
		.cfg    (cfg_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	word_req_t word_q[$];
	result_t   checksum_q[$];
	word_req_t next_req;
	result_t   want;
	result_t   predicted;

	logic [MODE_W-1:0] cur_mode = MODE_RESET;
	logic [IDX_W-1:0]  cur_index = INDEX_RESET;
	logic [WORD_W-1:0] sum_acc = '0;
	logic [8:0]        words_seen = '0;
	logic [WORD_W-1:0] lead_word = '0;

	int     errors = 0;
	int     words_made = 0;
	bit     in_fire = 1'b0;
	bit     pressure_on = 1'b0;
	int     hold_cnt = 0;
	int     burst_left = 0;
	int     gap_left = 0;
	int     stall_cnt = 0;
	stall_t stall_style = RDY_ALWAYS;

	// Folds one word into the running checksum and gives a result on the last word.
	function automatic bit fold_word(input logic [WORD_W-1:0] w_in, input logic is_last,
			output result_t r);
		logic [WORD_W-1:0] w;
		logic [WORD_W:0]   wide;
		logic [WORD_W-1:0] s;
		bit                in_first;
		r = '0;
		w = w_in;
		in_first = (words_seen < BLOCK_WORDS);
		if (in_first && words_seen == {2'b00, cur_index})
			w = '0;
		if (words_seen == 0)
			lead_word = w;
		wide = {1'b0, sum_acc} + {1'b0, w};
		s = wide[WORD_W-1:0];
		if (cur_mode == MODE_BOOT && wide[WORD_W])
			s = s + 1'b1;
		sum_acc = s;
		if (in_first)
			words_seen = words_seen + 1'b1;
		if (!is_last)
			return 1'b0;
		if (int'(cur_index) >= BLOCK_WORDS || (cur_mode != MODE_STD && cur_mode != MODE_BOOT)) begin
			r.status = STATUS_NO_CHECK;
		end else if (cur_mode == MODE_STD) begin
			r.checksum = 32'd0 - s;
			r.status = STATUS_OK;
		end else if (s == lead_word) begin
			r.status = STATUS_BOOT_MATCH;
		end else begin
			r.checksum = ~s;
			r.status = STATUS_OK;
		end
		sum_acc = '0;
		words_seen = '0;
		lead_word = '0;
		return 1'b1;
	endfunction

	always @(posedge clk) begin
		in_fire = arst_n && data_if.valid && data_if.ready;
		if (arst_n) begin
			if (cfg_if.valid && cfg_if.ready) begin
				case (cfg_if.index)
					REG_MODE: cur_mode = cfg_if.data[MODE_W-1:0];
					REG_INDEX: cur_index = cfg_if.data[IDX_W-1:0];
					default: ;
				endcase
			end
			if (in_fire && fold_word(data_if.word, data_if.last, predicted))
				checksum_q.insert(checksum_q.size(), predicted);
			if (result_if.valid && result_if.ready) begin
				if (checksum_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, got checksum %h status %0d",
						$time, result_if.checksum, result_if.status);
					errors++;
				end else begin
					want = checksum_q.pop_front();
					if (result_if.checksum !== want.checksum) begin
						$display("%0t: checksum expected %h, got %h",
							$time, want.checksum, result_if.checksum);
						errors++;
					end
					if (result_if.status !== want.status) begin
						$display("%0t: status expected %0d, got %0d",
							$time, want.status, result_if.status);
						errors++;
					end
				end
			end
		end
	end

	// The sender holds each request until it is taken, then works in bursts and gaps.
	always @(negedge clk) begin
		if (arst_n && (!data_if.valid || in_fire)) begin
			if (gap_left > 0) begin
				data_if.valid <= 1'b0;
				gap_left--;
			end else if (word_q.size() > 0) begin
				next_req = word_q.pop_front();
				data_if.valid <= 1'b1;
				data_if.word <= next_req.word;
				data_if.last <= next_req.last;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				data_if.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		stall_cnt++;
		if (stall_cnt % 80 == 0)
			stall_style = stall_t'($urandom_range(0, 3));
		if (pressure_on && hold_cnt < HOLD_CYCLES) begin
			result_if.ready <= 1'b0;
			hold_cnt++;
		end else begin
			case (stall_style)
				RDY_ALWAYS: result_if.ready <= 1'b1;
				RDY_COIN: result_if.ready <= 1'($urandom_range(0, 1));
				RDY_SPARSE: result_if.ready <= ($urandom_range(0, 3) == 0);
				default: result_if.ready <= stall_cnt[2];
			endcase
		end
	end

	initial begin
		int cyc;
		for (cyc = 0; cyc < CYCLE_LIMIT; cyc++)
			@(posedge clk);
		$display("disk_block_checksum: mismatch");
		$finish;
	end

	task automatic add_word(input logic [WORD_W-1:0] w, input logic l);
		word_req_t req;
		req.word = w;
		req.last = l;
		word_q.insert(word_q.size(), req);
		words_made++;
	endtask

	task automatic add_block(input int len, input blk_kind_t kind);
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] w;
		x = $urandom;
		for (int i = 0; i < len; i++) begin
			case (kind)
				BLK_ONES: w = '1;
				BLK_EXTREME: w = $urandom_range(0, 1) ? '1 :
					($urandom_range(0, 1) ? 32'h8000_0000 : 32'h0);
				BLK_BOOT_MATCH: begin
					if (i == 0) begin
						w = $urandom;
					end else if (i % 2 == 1) begin
						x = $urandom;
						w = x;
					end else begin
						w = ~x;
					end
				end
				default: w = $urandom;
			endcase
			add_word(w, i == len - 1);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= val;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic write_mode(input logic [MODE_W-1:0] m);
		logic [CFG_DATA_W-1:0] d;
		d = CFG_DATA_W'($urandom);
		d[MODE_W-1:0] = m;
		write_reg(REG_MODE, d);
	endtask

	// Waits until every request is taken and every result has come, then lets the pipeline settle.
	task automatic drain();
		while (word_q.size() != 0 || data_if.valid || checksum_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int phase;
		int phase_words;
		int len;
		int pick;
		blk_kind_t kind;
		data_if.valid = 1'b0;
		data_if.word = '0;
		data_if.last = 1'b0;
		result_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_MODE;
		cfg_if.data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_word(32'h0, 1'b1);
		add_word(32'hFFFF_FFFF, 1'b1);
		add_word(32'h1, 1'b0);
		add_word(32'h2, 1'b0);
		add_word(32'h3, 1'b0);
		add_word(32'h4, 1'b0);
		add_word(32'h5, 1'b0);
		add_word(32'hFFFF_FFFF, 1'b1);
		drain();

		write_mode(MODE_BOOT);
		write_reg(REG_INDEX, 7'd0);
		add_word(32'hA5A5_5A5A, 1'b1);
		add_word(32'h1234_5678, 1'b0);
		add_word(32'hDEAD_BEEF, 1'b0);
		add_word(~32'hDEAD_BEEF, 1'b1);
		drain();

		write_reg(REG_INDEX, 7'd100);
		add_word(32'h1234_5678, 1'b0);
		add_word(32'hDEAD_BEEF, 1'b0);
		add_word(~32'hDEAD_BEEF, 1'b1);
		add_word(32'hFFFF_FFFF, 1'b0);
		add_word(32'hFFFF_FFFF, 1'b1);
		add_word(32'h8000_0000, 1'b0);
		add_word(32'h8000_0000, 1'b1);
		drain();

		write_mode(MODE_NONE);
		add_word(32'h1, 1'b0);
		add_word(32'h2, 1'b1);
		drain();
		write_reg(REG_MODE, 7'h7F);
		add_word(32'h3, 1'b1);
		drain();

		words_made = 0;
		phase = 0;
		while (words_made < RANDOM_WORDS) begin
			pick = $urandom_range(0, 19);
			if (pick < 2)
				write_mode(MODE_NONE);
			else if (pick < 3)
				write_mode(2'd3);
			else if (pick < 11)
				write_mode(MODE_STD);
			else
				write_mode(MODE_BOOT);
			pick = $urandom_range(0, 5);
			if (pick == 0)
				write_reg(REG_INDEX, 7'd0);
			else if (pick == 1)
				write_reg(REG_INDEX, 7'd127);
			else if (pick < 4)
				write_reg(REG_INDEX, 7'($urandom_range(0, 12)));
			else
				write_reg(REG_INDEX, 7'($urandom_range(0, 127)));

			if (phase == 3) begin
				pressure_on = 1'b1;
				for (int i = 0; i < 40; i++)
					add_block(1, BLK_RANDOM);
				drain();
				pressure_on = 1'b0;
			end

			phase_words = 0;
			while (phase_words < 80) begin
				pick = $urandom_range(0, 59);
				if (pick == 0)
					len = $urandom_range(250, 300);
				else if (pick < 5)
					len = $urandom_range(120, 135);
				else if (pick < 17)
					len = $urandom_range(13, 40);
				else
					len = $urandom_range(1, 12);
				pick = $urandom_range(0, 9);
				if (pick < 6) begin
					kind = BLK_RANDOM;
				end else if (pick < 8) begin
					kind = BLK_BOOT_MATCH;
					len = len | 1;
				end else if (pick < 9) begin
					kind = BLK_ONES;
				end else begin
					kind = BLK_EXTREME;
				end
				add_block(len, kind);
				phase_words += len;
			end
			drain();
			phase++;
		end

		if (errors == 0)
			$display("disk_block_checksum: match");
		else
			$display("disk_block_checksum: mismatch");
		$finish;
	end

endmodule
